// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL. Every check is clocked on clk and is
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/bbc_pkg.sv -----
`timescale 1ns / 1ps
package bbc_pkg;

    localparam int SLOTS          = 32;
    localparam int IDX_W          = $clog2(SLOTS);
    localparam int CNT_W          = $clog2(SLOTS + 1);
    localparam int SLOT_W         = 5;
    localparam int PAGE_W         = 16;
    localparam int SCALE_W        = 16;
    localparam int ROT_W          = 9;
    localparam int BYTES_W        = 32;
    localparam int STAMP_W        = 32;
    localparam int TOTAL_W        = 33;
    localparam int COUNT_W        = 6;
    localparam int BUDGET_W       = 12;
    localparam int MIB_SHIFT      = 20;
    localparam int BUDGET_BYTES_W = BUDGET_W + MIB_SHIFT;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [BUDGET_W-1:0] MIN_BUDGET_MIB   = BUDGET_W'(16);
    localparam logic [BUDGET_W-1:0] RESET_BUDGET_MIB = BUDGET_W'(256);

    localparam logic [2:0] MODE_INSERT  = 3'd0;
    localparam logic [2:0] MODE_GET     = 3'd1;
    localparam logic [2:0] MODE_PROBE   = 3'd2;
    localparam logic [2:0] MODE_CLOSEST = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    localparam logic EV_RESULT = 1'b0;
    localparam logic EV_EVICT  = 1'b1;

    // Register index decoded from the word address bit.
    localparam logic REG_BUDGET = 1'b0;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [SCALE_W-1:0] scale;
        logic [ROT_W-1:0]   rot;
    } key_t;

    typedef struct packed {
        key_t               key;
        logic [BYTES_W-1:0] bytes;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic               kind;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        key_t               key;
        logic [BYTES_W-1:0] bytes;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
        logic               last;
    } evt_t;

    typedef enum logic [2:0] {
        SCAN_MATCH  = 3'b001,
        SCAN_OLDEST = 3'b010,
        SCAN_CLOSE  = 3'b100
    } scan_t;

endpackage

// ----- sv/bbc_if.sv -----
`timescale 1ns / 1ps
interface bbc_cmd_if;
    import bbc_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [PAGE_W-1:0]  page_number;
    logic [SCALE_W-1:0] scale_code;
    logic [ROT_W-1:0]   rotation_deg;
    logic [BYTES_W-1:0] entry_bytes;

    modport source (output valid, mode, page_number, scale_code, rotation_deg,
                    entry_bytes, input ready);
    modport sink   (input valid, mode, page_number, scale_code, rotation_deg,
                    entry_bytes, output ready);
endinterface

interface bbc_evt_if;
    import bbc_pkg::*;
    logic               valid;
    logic               ready;
    logic               event_kind;
    logic               hit;
    logic [SLOT_W-1:0]  slot_index;
    logic [PAGE_W-1:0]  out_page;
    logic [SCALE_W-1:0] out_scale;
    logic [ROT_W-1:0]   out_rotation;
    logic [BYTES_W-1:0] out_bytes;
    logic [TOTAL_W-1:0] total_bytes;
    logic [COUNT_W-1:0] entry_count;
    logic               last;

    modport source (output valid, event_kind, hit, slot_index, out_page, out_scale,
                    out_rotation, out_bytes, total_bytes, entry_count, last,
                    input ready);
    modport sink   (input valid, event_kind, hit, slot_index, out_page, out_scale,
                    out_rotation, out_bytes, total_bytes, entry_count, last,
                    output ready);
endinterface

// ----- sv/bbc_ram.sv -----
`timescale 1ns / 1ps
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/byte_budget_lru_tag_cache.sv -----
`timescale 1ns / 1ps
// Size-aware LRU tag store for rendered pages. Commands arrive as items on the
// cmd channel (insert, get, probe, closest scale, clear); results leave as
// items on the evt channel, every eviction notice first and the command result
// last, marked by last. The budget register (MiB, floor 16) is written over the
// APB port; a lowered budget is enforced before the next command runs.
// Sequencing: a command is taken only while the sequencer is idle. Every table
// walk reads all 32 slots through the single entry RAM. Get, probe and closest
// take one walk; an insert takes one walk plus one more for each eviction it
// causes, and one more when the entry cannot fit at all. A budget drop adds one
// walk per evicted entry before the command itself. Clear and zero-size inserts
// take no walk.
// The output register holds a finished item while the sink stalls; the next
// item waits only for that register to free.
// Reset empties the table at once through per-slot valid bits, zeroes the byte
// total and access counter and sets the budget to 256 MiB; no clearing pass.
module byte_budget_lru_tag_cache
    import bbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    bbc_cmd_if.sink            cmd,
    bbc_evt_if.source          evt,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    `include "assert_macros.svh"

    typedef enum logic [13:0] {
        ST_IDLE       = 14'b00000000000001,
        ST_PRE_CHK    = 14'b00000000000010,
        ST_PRE_EVT    = 14'b00000000000100,
        ST_DISPATCH   = 14'b00000000001000,
        ST_SCAN       = 14'b00000000010000,
        ST_INS_CHK    = 14'b00000000100000,
        ST_INS_EVT    = 14'b00000001000000,
        ST_INS_FAIL   = 14'b00000010000000,
        ST_INS_RES    = 14'b00000100000000,
        ST_INS_COMMIT = 14'b00001000000000,
        ST_FULL_EVT   = 14'b00010000000000,
        ST_FULL_WR    = 14'b00100000000000,
        ST_LOOK       = 14'b01000000000000,
        ST_SIMPLE     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    scan_t  kind_reg, kind_next;
    logic   skip_en_reg, skip_en_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic   pend_reg, pend_next;
    logic [IDX_W-1:0] idx_d_reg, idx_d_next;
    logic   vld_d_reg, vld_d_next;

    logic [2:0]         req_mode_reg, req_mode_next;
    key_t               req_key_reg, req_key_next;
    logic [BYTES_W-1:0] req_bytes_reg, req_bytes_next;

    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [STAMP_W-1:0] counter_reg, counter_next;
    logic [BUDGET_W-1:0] budget_reg;

    logic               m_found_reg, m_found_next;
    logic [IDX_W-1:0]   m_idx_reg, m_idx_next;
    logic [BYTES_W-1:0] m_size_reg, m_size_next;
    logic               fr_found_reg, fr_found_next;
    logic [IDX_W-1:0]   fr_idx_reg, fr_idx_next;
    logic               b_found_reg, b_found_next;
    logic [IDX_W-1:0]   b_idx_reg, b_idx_next;
    key_t               b_key_reg, b_key_next;
    logic [BYTES_W-1:0] b_size_reg, b_size_next;
    logic [STAMP_W-1:0] b_metric_reg, b_metric_next;

    logic ov_reg, ov_next;
    evt_t evt_reg, evt_next;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    entry_t             ram_wdata, ram_rdata;

    logic [BUDGET_W-1:0]       budget_mib;
    logic [BUDGET_BYTES_W-1:0] budget_bytes;
    logic                      out_free;
    logic                      over_ins;
    logic [SCALE_W-1:0]        scale_gap;

    logic        start;
    scan_t       start_kind;
    logic        start_skip;
    state_t      start_ret;
    logic        ev;
    logic [IDX_W-1:0]   ev_idx;
    logic [BYTES_W-1:0] ev_size;
    key_t        ev_key;
    logic        emit;
    evt_t        emit_data;

    bbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration port: only bit 2 of the address selects a register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUDGET) ? PDATA_W'(budget_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= RESET_BUDGET_MIB;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_BUDGET)
        begin
            budget_reg <= pwdata[BUDGET_W-1:0];
        end
    end

    assign budget_mib   = (budget_reg < MIN_BUDGET_MIB) ? MIN_BUDGET_MIB : budget_reg;
    assign budget_bytes = {budget_mib, {MIB_SHIFT{1'b0}}};
    assign out_free     = !ov_reg || evt.ready;

    // The total always covers the matched entry's size, so this cannot wrap.
    assign over_ins = ({1'b0, total_reg} + (TOTAL_W + 1)'(req_bytes_reg)
                       - (TOTAL_W + 1)'(m_size_reg)) > (TOTAL_W + 1)'(budget_bytes);

    assign scale_gap = (ram_rdata.key.scale > req_key_reg.scale)
                     ? ram_rdata.key.scale - req_key_reg.scale
                     : req_key_reg.scale - ram_rdata.key.scale;

    assign cmd.ready        = (state_reg == ST_IDLE);
    assign evt.valid        = ov_reg;
    assign evt.event_kind   = evt_reg.kind;
    assign evt.hit          = evt_reg.hit;
    assign evt.slot_index   = evt_reg.slot;
    assign evt.out_page     = evt_reg.key.page;
    assign evt.out_scale    = evt_reg.key.scale;
    assign evt.out_rotation = evt_reg.key.rot;
    assign evt.out_bytes    = evt_reg.bytes;
    assign evt.total_bytes  = evt_reg.total;
    assign evt.entry_count  = evt_reg.count;
    assign evt.last         = evt_reg.last;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        kind_next      = kind_reg;
        skip_en_next   = skip_en_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        idx_d_next     = idx_d_reg;
        vld_d_next     = vld_d_reg;
        req_mode_next  = req_mode_reg;
        req_key_next   = req_key_reg;
        req_bytes_next = req_bytes_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        counter_next   = counter_reg;
        m_found_next   = m_found_reg;
        m_idx_next     = m_idx_reg;
        m_size_next    = m_size_reg;
        fr_found_next  = fr_found_reg;
        fr_idx_next    = fr_idx_reg;
        b_found_next   = b_found_reg;
        b_idx_next     = b_idx_reg;
        b_key_next     = b_key_reg;
        b_size_next    = b_size_reg;
        b_metric_next  = b_metric_reg;
        ov_next        = ov_reg;
        evt_next       = evt_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        start          = 1'b0;
        start_kind     = SCAN_MATCH;
        start_skip     = 1'b0;
        start_ret      = ST_IDLE;
        ev             = 1'b0;
        ev_idx         = '0;
        ev_size        = '0;
        ev_key         = '0;
        emit           = 1'b0;
        emit_data      = '0;

        // One slot of the walk is judged per cycle, in the cycle after its read.
        if (pend_reg)
        begin
            unique case (kind_reg)
                SCAN_MATCH:
                begin
                    if (vld_d_reg && ram_rdata.key == req_key_reg && !m_found_reg)
                    begin
                        m_found_next = 1'b1;
                        m_idx_next   = idx_d_reg;
                        m_size_next  = ram_rdata.bytes;
                    end
                    if (!vld_d_reg && !fr_found_reg)
                    begin
                        fr_found_next = 1'b1;
                        fr_idx_next   = idx_d_reg;
                    end
                end
                SCAN_OLDEST:
                begin
                    if (vld_d_reg && !(skip_en_reg && idx_d_reg == m_idx_reg)
                        && (!b_found_reg || ram_rdata.stamp < b_metric_reg))
                    begin
                        b_found_next  = 1'b1;
                        b_idx_next    = idx_d_reg;
                        b_key_next    = ram_rdata.key;
                        b_size_next   = ram_rdata.bytes;
                        b_metric_next = ram_rdata.stamp;
                    end
                end
                SCAN_CLOSE:
                begin
                    if (vld_d_reg && ram_rdata.key.page == req_key_reg.page
                        && ram_rdata.key.rot == req_key_reg.rot
                        && (!b_found_reg || STAMP_W'(scale_gap) < b_metric_reg))
                    begin
                        b_found_next  = 1'b1;
                        b_idx_next    = idx_d_reg;
                        b_key_next    = ram_rdata.key;
                        b_size_next   = ram_rdata.bytes;
                        b_metric_next = STAMP_W'(scale_gap);
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    req_mode_next  = cmd.mode;
                    req_key_next   = '{page: cmd.page_number, scale: cmd.scale_code,
                                       rot: cmd.rotation_deg};
                    req_bytes_next = cmd.entry_bytes;
                    state_next     = ST_PRE_CHK;
                end
            end
            ST_PRE_CHK:
            begin
                // A lowered budget is enforced before the command runs.
                if (total_reg > TOTAL_W'(budget_bytes))
                begin
                    start      = 1'b1;
                    start_kind = SCAN_OLDEST;
                    start_ret  = ST_PRE_EVT;
                end
                else
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_PRE_EVT:
            begin
                if (!b_found_reg)
                begin
                    state_next = ST_DISPATCH;
                end
                else if (out_free)
                begin
                    ev         = 1'b1;
                    ev_idx     = b_idx_reg;
                    ev_size    = b_size_reg;
                    ev_key     = b_key_reg;
                    state_next = ST_PRE_CHK;
                end
            end
            ST_DISPATCH:
            begin
                priority case (req_mode_reg)
                    MODE_INSERT:
                    begin
                        if (req_bytes_reg == '0)
                        begin
                            state_next = ST_SIMPLE;
                        end
                        else
                        begin
                            start     = 1'b1;
                            start_ret = ST_INS_CHK;
                        end
                    end
                    MODE_GET, MODE_PROBE:
                    begin
                        start     = 1'b1;
                        start_ret = ST_LOOK;
                    end
                    MODE_CLOSEST:
                    begin
                        start      = 1'b1;
                        start_kind = SCAN_CLOSE;
                        start_ret  = ST_LOOK;
                    end
                    MODE_CLEAR:
                    begin
                        valid_next = '0;
                        count_next = '0;
                        total_next = '0;
                        state_next = ST_SIMPLE;
                    end
                    default:
                    begin
                        state_next = ST_SIMPLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (cnt_reg < CNT_W'(SLOTS))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cnt_reg[IDX_W-1:0];
                    idx_d_next = cnt_reg[IDX_W-1:0];
                    vld_d_next = valid_reg[cnt_reg[IDX_W-1:0]];
                    pend_next  = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ret_reg;
                    end
                end
            end
            ST_INS_CHK:
            begin
                if (over_ins)
                begin
                    start      = 1'b1;
                    start_kind = SCAN_OLDEST;
                    start_skip = m_found_reg;
                    start_ret  = ST_INS_EVT;
                end
                else
                begin
                    state_next = ST_INS_COMMIT;
                end
            end
            ST_INS_EVT:
            begin
                if (!b_found_reg)
                begin
                    state_next = ST_INS_FAIL;
                end
                else if (out_free)
                begin
                    ev         = 1'b1;
                    ev_idx     = b_idx_reg;
                    ev_size    = b_size_reg;
                    ev_key     = b_key_reg;
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_FAIL:
            begin
                // The entry does not fit even alone: an old copy of the key goes.
                if (!m_found_reg)
                begin
                    state_next = ST_INS_RES;
                end
                else if (out_free)
                begin
                    ev         = 1'b1;
                    ev_idx     = m_idx_reg;
                    ev_size    = m_size_reg;
                    ev_key     = req_key_reg;
                    state_next = ST_INS_RES;
                end
            end
            ST_INS_RES:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_data.hit  = m_found_reg;
                    emit_data.slot = m_found_reg ? SLOT_W'(m_idx_reg) : '0;
                    emit_data.key  = req_key_reg;
                    emit_data.bytes = req_bytes_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_INS_COMMIT:
            begin
                if (m_found_reg)
                begin
                    if (out_free)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = m_idx_reg;
                        ram_wdata       = '{key: req_key_reg, bytes: req_bytes_reg,
                                            stamp: counter_reg};
                        counter_next    = counter_reg + STAMP_W'(1);
                        total_next      = total_reg - TOTAL_W'(m_size_reg)
                                        + TOTAL_W'(req_bytes_reg);
                        emit            = 1'b1;
                        emit_data.hit   = 1'b1;
                        emit_data.slot  = SLOT_W'(m_idx_reg);
                        emit_data.key   = req_key_reg;
                        emit_data.bytes = req_bytes_reg;
                        state_next      = ST_IDLE;
                    end
                end
                else if (fr_found_reg)
                begin
                    if (out_free)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = fr_idx_reg;
                        ram_wdata       = '{key: req_key_reg, bytes: req_bytes_reg,
                                            stamp: counter_reg};
                        counter_next    = counter_reg + STAMP_W'(1);
                        valid_next[fr_idx_reg] = 1'b1;
                        count_next      = count_reg + COUNT_W'(1);
                        total_next      = total_reg + TOTAL_W'(req_bytes_reg);
                        emit            = 1'b1;
                        emit_data.slot  = SLOT_W'(fr_idx_reg);
                        emit_data.key   = req_key_reg;
                        emit_data.bytes = req_bytes_reg;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    // Full table: the oldest entry makes room.
                    start      = 1'b1;
                    start_kind = SCAN_OLDEST;
                    start_ret  = ST_FULL_EVT;
                end
            end
            ST_FULL_EVT:
            begin
                if (out_free)
                begin
                    ev         = 1'b1;
                    ev_idx     = b_idx_reg;
                    ev_size    = b_size_reg;
                    ev_key     = b_key_reg;
                    state_next = ST_FULL_WR;
                end
            end
            ST_FULL_WR:
            begin
                if (out_free)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = b_idx_reg;
                    ram_wdata       = '{key: req_key_reg, bytes: req_bytes_reg,
                                        stamp: counter_reg};
                    counter_next    = counter_reg + STAMP_W'(1);
                    valid_next[b_idx_reg] = 1'b1;
                    count_next      = count_reg + COUNT_W'(1);
                    total_next      = total_reg + TOTAL_W'(req_bytes_reg);
                    emit            = 1'b1;
                    emit_data.slot  = SLOT_W'(b_idx_reg);
                    emit_data.key   = req_key_reg;
                    emit_data.bytes = req_bytes_reg;
                    state_next      = ST_IDLE;
                end
            end
            ST_LOOK:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (req_mode_reg == MODE_CLOSEST)
                    begin
                        if (b_found_reg)
                        begin
                            emit_data.hit   = 1'b1;
                            emit_data.slot  = SLOT_W'(b_idx_reg);
                            emit_data.key   = b_key_reg;
                            emit_data.bytes = b_size_reg;
                        end
                    end
                    else if (m_found_reg)
                    begin
                        emit_data.hit   = 1'b1;
                        emit_data.slot  = SLOT_W'(m_idx_reg);
                        emit_data.key   = req_key_reg;
                        emit_data.bytes = m_size_reg;
                        if (req_mode_reg == MODE_GET)
                        begin
                            ram_we       = 1'b1;
                            ram_waddr    = m_idx_reg;
                            ram_wdata    = '{key: req_key_reg, bytes: m_size_reg,
                                             stamp: counter_reg};
                            counter_next = counter_reg + STAMP_W'(1);
                        end
                    end
                end
            end
            ST_SIMPLE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    // A zero-size insert echoes its key; other cases report a zero key and size.
                    if (req_mode_reg == MODE_INSERT)
                    begin
                        emit_data.key = req_key_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (start)
        begin
            kind_next    = start_kind;
            skip_en_next = start_skip;
            ret_next     = start_ret;
            cnt_next     = '0;
            pend_next    = 1'b0;
            state_next   = ST_SCAN;
            if (start_kind == SCAN_MATCH)
            begin
                m_found_next  = 1'b0;
                m_size_next   = '0;
                fr_found_next = 1'b0;
            end
            else
            begin
                b_found_next = 1'b0;
            end
        end

        if (ev)
        begin
            valid_next[ev_idx] = 1'b0;
            count_next         = count_reg - COUNT_W'(1);
            total_next         = (total_reg >= TOTAL_W'(ev_size))
                               ? total_reg - TOTAL_W'(ev_size) : '0;
            // An evicted slot may now be the lowest free one for the insert.
            if (!fr_found_reg || ev_idx < fr_idx_reg)
            begin
                fr_found_next = 1'b1;
                fr_idx_next   = ev_idx;
            end
            emit               = 1'b1;
            emit_data.kind     = EV_EVICT;
            emit_data.slot     = SLOT_W'(ev_idx);
            emit_data.key      = ev_key;
            emit_data.bytes    = ev_size;
        end
        else if (emit)
        begin
            emit_data.kind = EV_RESULT;
            emit_data.last = 1'b1;
        end

        if (emit)
        begin
            emit_data.total = total_next;
            emit_data.count = count_next;
            ov_next         = 1'b1;
            evt_next        = emit_data;
        end
        else if (evt.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            kind_reg     <= SCAN_MATCH;
            skip_en_reg  <= 1'b0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            valid_reg    <= '0;
            count_reg    <= '0;
            total_reg    <= '0;
            counter_reg  <= '0;
            m_found_reg  <= 1'b0;
            fr_found_reg <= 1'b0;
            b_found_reg  <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            kind_reg     <= kind_next;
            skip_en_reg  <= skip_en_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            counter_reg  <= counter_next;
            m_found_reg  <= m_found_next;
            fr_found_reg <= fr_found_next;
            b_found_reg  <= b_found_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_d_reg     <= idx_d_next;
        vld_d_reg     <= vld_d_next;
        req_mode_reg  <= req_mode_next;
        req_key_reg   <= req_key_next;
        req_bytes_reg <= req_bytes_next;
        m_idx_reg     <= m_idx_next;
        m_size_reg    <= m_size_next;
        fr_idx_reg    <= fr_idx_next;
        b_idx_reg     <= b_idx_next;
        b_key_reg     <= b_key_next;
        b_size_reg    <= b_size_next;
        b_metric_reg  <= b_metric_next;
        evt_reg       <= evt_next;
    end

    // The entry count must track the valid bits exactly.
    `ASSERT_ALWAYS(a_count_matches, count_reg == COUNT_W'($countones(valid_reg)), "entry count out of step with valid bits")
    // The walk counter never runs past the table.
    `ASSERT_ALWAYS(a_scan_bound, cnt_reg <= CNT_W'(SLOTS), "table walk ran past the last slot")
    // A notice is never a hit and never closes a command.
    `ASSERT_IMPLIES(a_notice_shape, ov_reg && evt_reg.kind == EV_EVICT, !evt_reg.hit && !evt_reg.last, "eviction notice carries hit or last")
    // A read is only issued while walking the table.
    `ASSERT_IMPLIES(a_read_in_scan, ram_re, state_reg == ST_SCAN, "entry read outside a table walk")

endmodule
